>>> rtl/core/angate_pkg.sv
// ----------------------------------------------------------------------------
// angate_pkg: shared types and constants for the adaptive noise gate
// Widths, reset values, configuration register codes and the structs that
// pass settings, tracker state and per-chunk results between modules.
// ----------------------------------------------------------------------------
package angate_pkg;

	localparam int unsigned RmsW    = 16;
	localparam int unsigned ChunkW  = 10;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned FloorW  = 20;
	localparam int unsigned QuietW  = 17;
	localparam int unsigned ProdW   = FloorW + CfgW;
	localparam int unsigned ThrW    = ProdW - 8;

	localparam int unsigned InDataW  = 32;
	localparam int unsigned OutDataW = 24;
	localparam int unsigned CfgIdxW  = 2;

	// Floor tracking shifts
	localparam int unsigned LevelShift    = 4;
	localparam int unsigned FallShift     = 2;
	localparam int unsigned RiseShift     = 7;
	localparam int unsigned RiseLoudShift = 9;

	// Reset values
	localparam logic [CfgW-1:0]   RatioReset = 16'd48;
	localparam logic [CfgW-1:0]   MinReset   = 16'd200;
	localparam logic [CfgW-1:0]   HangReset  = 16'd800;
	localparam logic [QuietW-1:0] QuietReset = '1;

	// Configuration register codes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_RATIO     = 2'd0,
		CFG_MIN_LEVEL = 2'd1,
		CFG_HANG      = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CfgW-1:0] ratio;
		logic [CfgW-1:0] min_level;
		logic [CfgW-1:0] hang;
	} cfg_t;

	typedef struct packed {
		logic [FloorW-1:0] floor_level;
		logic              primed;
		logic [QuietW-1:0] quiet_time;
	} state_t;

	typedef struct packed {
		logic [FloorW-1:0] noise_floor;
		logic              loud;
		logic              gate_open;
	} result_t;

endpackage

>>> rtl/core/angate_step.sv
// ----------------------------------------------------------------------------
// angate_step: one chunk update of the noise gate
// Forms the threshold, decides loudness, moves the noise floor and advances
// the hang counter. Pure combinational logic between the block's registers.
// ----------------------------------------------------------------------------
module angate_step (
	input  logic [angate_pkg::RmsW-1:0]   rms,
	input  logic [angate_pkg::ChunkW-1:0] chunk_len,
	input  angate_pkg::cfg_t              cfg,
	input  angate_pkg::state_t            st,
	output angate_pkg::state_t            st_next,
	output angate_pkg::result_t           res
);

	logic [angate_pkg::FloorW-1:0] level;
	logic [angate_pkg::FloorW-1:0] floor_eff;
	logic [angate_pkg::ProdW-1:0]  prod;
	logic [angate_pkg::ThrW-1:0]   thr;
	logic                          loud;
	logic [angate_pkg::FloorW-1:0] gap_dn;
	logic [angate_pkg::FloorW-1:0] gap_up;
	logic [angate_pkg::FloorW-1:0] floor_new;
	logic [angate_pkg::QuietW-1:0] hang_ext;
	logic [angate_pkg::QuietW-1:0] quiet_new;

	// Scale the level; the first chunk primes the floor
	assign level     = {rms, {angate_pkg::LevelShift{1'b0}}};
	assign floor_eff = st.primed ? st.floor_level : level;

	// Threshold at full product width, then the larger of it and the minimum
	assign prod = angate_pkg::ProdW'(floor_eff) * angate_pkg::ProdW'(cfg.ratio);
	assign thr  = prod[angate_pkg::ProdW-1:8];
	assign loud = (angate_pkg::ThrW'(rms) >= thr) && (rms >= cfg.min_level);

	// Move the floor toward the level: fast down, slow up, slower when loud
	assign gap_dn = floor_eff - level;
	assign gap_up = level - floor_eff;
	always_comb begin
		if (level < floor_eff) begin
			floor_new = floor_eff - (gap_dn >> angate_pkg::FallShift);
		end else if (loud) begin
			floor_new = floor_eff + (gap_up >> angate_pkg::RiseLoudShift);
		end else begin
			floor_new = floor_eff + (gap_up >> angate_pkg::RiseShift);
		end
	end

	// Hang counter: clear on loud, add while still within the hang time
	assign hang_ext = angate_pkg::QuietW'(cfg.hang);
	always_comb begin
		if (loud) begin
			quiet_new = '0;
		end else if (st.quiet_time < hang_ext) begin
			quiet_new = st.quiet_time + angate_pkg::QuietW'(chunk_len);
		end else begin
			quiet_new = st.quiet_time;
		end
	end

	assign st_next.floor_level = floor_new;
	assign st_next.primed      = 1'b1;
	assign st_next.quiet_time  = quiet_new;

	assign res.noise_floor = floor_new;
	assign res.loud        = loud;
	assign res.gate_open   = quiet_new < hang_ext;

endmodule

>>> rtl/core/adaptive_noise_gate.sv
// ----------------------------------------------------------------------------
// adaptive_noise_gate: energy-based voice activity gate with noise tracking
// Input is held in the s1 registers and the result in res_q; one chunk per
// cycle unless the result stalls, as the angate_step update is combinational.
// Reset clears the floor, marks it unprimed, sets the gate closed and loads
// the default ratio, minimum level and hang time.
// ----------------------------------------------------------------------------
module adaptive_noise_gate (
	input  logic                             clk,
	input  logic                             arst_n,
	// rms [15:0], chunk_len [25:16], zero [31:26]
	input  logic [angate_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// gate_open [0], loud [1], noise_floor [21:2], zero [23:22]
	output logic [angate_pkg::OutDataW-1:0]  m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [angate_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [angate_pkg::CfgW-1:0]      cfg_data
);

	logic [angate_pkg::RmsW-1:0]   rms_s1;
	logic [angate_pkg::ChunkW-1:0] chunk_s1;
	logic                          valid_s1;
	logic                          advance;
	angate_pkg::cfg_t              cfg_q;
	angate_pkg::state_t            state_q;
	angate_pkg::state_t            state_next;
	angate_pkg::result_t           res;
	angate_pkg::result_t           res_q;
	logic                          out_valid_q;

	// Step while the result register is free or being drained
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rms_s1   <= s_axis_tdata[angate_pkg::RmsW-1:0];
			chunk_s1 <= s_axis_tdata[angate_pkg::RmsW +: angate_pkg::ChunkW];
		end
	end

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio     <= angate_pkg::RatioReset;
			cfg_q.min_level <= angate_pkg::MinReset;
			cfg_q.hang      <= angate_pkg::HangReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				angate_pkg::CFG_RATIO:     cfg_q.ratio     <= cfg_data;
				angate_pkg::CFG_MIN_LEVEL: cfg_q.min_level <= cfg_data;
				angate_pkg::CFG_HANG:      cfg_q.hang      <= cfg_data;
				default: ;
			endcase
		end
	end

	angate_step u_step (
		.rms       (rms_s1),
		.chunk_len (chunk_s1),
		.cfg       (cfg_q),
		.st        (state_q),
		.st_next   (state_next),
		.res       (res)
	);

	// Tracker state advances once per processed chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.floor_level <= '0;
			state_q.primed      <= 1'b0;
			state_q.quiet_time  <= angate_pkg::QuietReset;
		end else if (valid_s1 && advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.noise_floor, res_q.loud, res_q.gate_open};

	// Checks
	a_unprimed_floor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.primed |-> state_q.floor_level == '0)
		else $error("floor moved before priming");

	a_primed_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (state_q.primed && out_valid_q))
		else $error("processed chunk did not prime floor or raise result");

	a_loud_clears_hang: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && res.loud) |=> state_q.quiet_time == '0)
		else $error("loud chunk did not clear hang counter");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

>>> tb/sv/adaptive_noise_gate_checker.sv
// ----------------------------------------------------------------------------
// adaptive_noise_gate_checker: scoreboard for the adaptive noise gate
// Watches the chunk, result and register write channels. Tracks its own
// copy of the settings, noise floor, priming flag and hang counter, works out
// the gate result for every accepted chunk and compares each result
// transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [angate_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [angate_pkg::OutDataW-1:0]  m_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [angate_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [angate_pkg::CfgW-1:0]      cfg_data,
	output int                               errors,
	output int                               pending,
	output int                               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import angate_pkg::*;

	localparam int unsigned ResW = $bits(result_t);

	cfg_t              gate_cfg;
	logic [FloorW-1:0] floor_est;
	logic              primed;
	logic [QuietW-1:0] quiet_acc;
	result_t           due_results[$];

	// Advance the floor and hang tracking by one chunk and queue its result
	task automatic track_chunk(input logic [RmsW-1:0] rms, input logic [ChunkW-1:0] dur);
		logic [FloorW-1:0] level;
		logic [ProdW-1:0]  product;
		logic [ThrW-1:0]   thresh;
		result_t           res;
		level = FloorW'(rms) << LevelShift;
		if (!primed) begin
			floor_est = level;
			primed = 1'b1;
		end
		// threshold at full product width, then floored at the minimum level
		product = ProdW'(floor_est) * ProdW'(gate_cfg.ratio);
		thresh = ThrW'(product >> 8);
		if (thresh < ThrW'(gate_cfg.min_level)) begin
			thresh = ThrW'(gate_cfg.min_level);
		end
		res.loud = ThrW'(rms) >= thresh;
		// fall fast toward quiet chunks, rise slowly, slower still on speech
		if (level < floor_est) begin
			floor_est = floor_est - ((floor_est - level) >> FallShift);
		end else begin
			floor_est = floor_est + ((level - floor_est) >> (res.loud ? RiseLoudShift : RiseShift));
		end
		// hang counter: clear on speech, add only while below the hang time
		if (res.loud) begin
			quiet_acc = '0;
		end else if (quiet_acc < QuietW'(gate_cfg.hang)) begin
			quiet_acc = quiet_acc + QuietW'(dur);
		end
		res.gate_open = quiet_acc < QuietW'(gate_cfg.hang);
		res.noise_floor = floor_est;
		due_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		logic    pad_ok;
		if (!arst_n) begin
			gate_cfg.ratio = RatioReset;
			gate_cfg.min_level = MinReset;
			gate_cfg.hang = HangReset;
			floor_est = '0;
			primed = 1'b0;
			quiet_acc = QuietReset;
			due_results.delete();
			errors = 0;
			checked = 0;
		end else begin
			// compare a result transaction before queueing this edge's chunk
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[ResW-1:0];
				pad_ok = m_axis_tdata[OutDataW-1:ResW] === '0;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result open=%0b loud=%0b floor=%0d",
						$time, got.gate_open, got.loud, got.noise_floor);
				end else begin
					want = due_results.pop_front();
					checked++;
					if (got.gate_open !== want.gate_open || got.loud !== want.loud ||
							got.noise_floor !== want.noise_floor || !pad_ok) begin
						errors++;
						$display("%0t ns: result %0d expected open=%0b loud=%0b floor=%0d",
							$time, checked, want.gate_open, want.loud, want.noise_floor);
						$display("%0t ns: result %0d actual   open=%0b loud=%0b floor=%0d pad=%0h",
							$time, checked, got.gate_open, got.loud, got.noise_floor,
							m_axis_tdata[OutDataW-1:ResW]);
					end
				end
			end
			// register write; unknown indexes change nothing
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RATIO: begin
						gate_cfg.ratio = cfg_data;
					end
					CFG_MIN_LEVEL: begin
						gate_cfg.min_level = cfg_data;
					end
					CFG_HANG: begin
						gate_cfg.hang = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_chunk(s_axis_tdata[RmsW-1:0], s_axis_tdata[RmsW +: ChunkW]);
			end
		end
		pending = due_results.size();
	end

endmodule

>>> tb/sv/adaptive_noise_gate_test.sv
// ----------------------------------------------------------------------------
// adaptive_noise_gate_test: top-level testbench for the adaptive noise gate
// Drives chunk levels and durations under several gate settings, including
// the extremes, with random gaps on both streams and one long result stall.
// Checking is done by adaptive_noise_gate_checker beside the block.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_test;
	timeunit 1ns;
	timeprecision 1ps;

	import angate_pkg::*;

	localparam int PipeDepth = 2;
	localparam int StallLimit = 2000;
	localparam int HoldCycles = 300;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;

	int   errors;
	int   pending;
	int   checked;
	int   chunks_sent = 0;
	int   reg_writes = 0;
	int   settings_seen = 0;
	int   quiet_cycles = 0;
	int   hold_req = 0;
	int   hold_left = 0;
	logic src_gaps = 1'b1;
	logic snk_gaps = 1'b1;

	adaptive_noise_gate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	adaptive_noise_gate_checker CHK (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random backpressure plus a requested long hold-off
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = !snk_gaps || ($urandom_range(99) >= 13);
		end
	end

	// Watchdog: end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= StallLimit) begin
				$display("%0t ns: no transaction for %0d cycles", $time, StallLimit);
				$display("adaptive_noise_gate_test failed");
				$finish;
			end
		end
	end

	// Offer one chunk and hold it until accepted; starts and ends at a falling edge
	task automatic send_chunk(input logic [RmsW-1:0] rms, input logic [ChunkW-1:0] dur);
		while (src_gaps && $urandom_range(99) < 13) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = InDataW'({dur, rms});
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		chunks_sent++;
		@(negedge clk);
	endtask

	// Let every outstanding result drain, then allow the pipeline to settle
	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (PipeDepth + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		wait_idle();
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_gate(input logic [CfgW-1:0] ratio, input logic [CfgW-1:0] min_lvl,
			input logic [CfgW-1:0] hang);
		write_reg(CFG_RATIO, ratio);
		write_reg(CFG_MIN_LEVEL, min_lvl);
		write_reg(CFG_HANG, hang);
		settings_seen++;
	endtask

	// Background noise around a base level with speech bursts, plus raw noise items
	task automatic run_chunks(input int count, input int base);
		int               burst;
		int               pick;
		int               val;
		logic [RmsW-1:0]  rms;
		logic [ChunkW-1:0] dur;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				rms = RmsW'($urandom);
				dur = ChunkW'($urandom);
			end else begin
				if (burst == 0 && $urandom_range(99) < 8) begin
					burst = $urandom_range(12, 1);
				end
				if (burst != 0) begin
					val = base * $urandom_range(8, 1) + $urandom_range(base / 4);
					burst--;
				end else begin
					val = base - base / 8 + $urandom_range(base / 4);
				end
				rms = (val > 65535) ? 16'hFFFF : val[15:0];
				pick = $urandom_range(99);
				dur = (pick < 5) ? 10'd0 : (pick < 10) ? 10'h3FF : 10'($urandom_range(64, 1));
			end
			send_chunk(rms, dur);
		end
		s_axis_tvalid = 1'b0;
	endtask

	initial begin
		logic [CfgW-1:0] ratio;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed at reset settings: prime at zero, minimum level edge,
		// full-scale levels and durations, hang expiry and zero-length chunks
		send_chunk(16'd0, 10'd0);
		send_chunk(16'd200, 10'd5);
		send_chunk(16'd199, 10'h3FF);
		send_chunk(16'hFFFF, 10'h3FF);
		send_chunk(16'd0, 10'h3FF);
		send_chunk(16'd0, 10'd0);
		send_chunk(16'd1, 10'd400);
		send_chunk(16'd1, 10'd399);
		send_chunk(16'd1, 10'd1);
		send_chunk(16'd1, 10'd1);
		send_chunk(16'hFFFF, 10'd0);
		send_chunk(16'h5555, 10'h155);
		send_chunk(16'hAAAA, 10'h2AA);
		send_chunk(16'd0, 10'h3FF);
		send_chunk(16'd0, 10'h3FF);
		s_axis_tvalid = 1'b0;
		settings_seen++;
		run_chunks(130, 400);

		// Lowest settings: every chunk is loud and the gate never opens
		set_gate(16'd0, 16'd0, 16'd0);
		run_chunks(80, $urandom_range(2000, 10));

		// Highest settings with no gaps on either side
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		set_gate(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_chunks(100, 20000);
		src_gaps = 1'b1;
		snk_gaps = 1'b1;

		// Unused register index must leave the settings alone
		set_gate(16'd48, 16'd200, 16'd800);
		write_reg(CFG_SPARE, 16'($urandom));
		hold_req = HoldCycles;
		run_chunks(130, $urandom_range(3000, 20));

		// Random settings, with a large ratio now and then
		for (int p = 0; p < 5; p++) begin
			ratio = ($urandom_range(99) < 20) ? 16'hFFFF : 16'($urandom_range(128, 8));
			set_gate(ratio, 16'($urandom_range(2000)), 16'($urandom_range(2000)));
			run_chunks(130, $urandom_range(3000, 20));
		end

		wait_idle();
		repeat (PipeDepth + 4) @(negedge clk);
		$display("Sent %0d chunks and checked %0d results under %0d gate settings,",
			chunks_sent, checked, settings_seen);
		$display("with %0d register writes, one long result stall and %0d mismatches.",
			reg_writes, errors);
		if (errors == 0 && pending == 0) begin
			$display("adaptive_noise_gate_test passed");
		end else begin
			$display("adaptive_noise_gate_test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/angate_pkg.sv
rtl/core/angate_step.sv
rtl/core/adaptive_noise_gate.sv
tb/sv/adaptive_noise_gate_checker.sv
tb/sv/adaptive_noise_gate_test.sv
